>>> rtl/core/phtl_pkg.sv
// ---------------------------------------------------------------------------
// phtl_pkg: shared types and constants of the point-in-brick locator
// Transaction structs, controller command group, tetra node tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phtl_pkg;

  localparam int COORD_W          = 32;
  localparam int DIFF_W           = 33;
  localparam int MOP_W            = 35;
  localparam int PROD_W           = 70;
  localparam int MINOR_W          = 67;
  localparam int MLO_W            = 34;
  localparam int DET_W            = 104;
  localparam int TOL_W            = 16;
  localparam int WEIGHT_W         = 32;
  localparam int NODE_COUNT       = 8;
  localparam int DET_COUNT        = 5;
  localparam int QUOT_BITS        = 31;
  localparam int WEIGHT_FRAC_DEF  = 30;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam logic       ACT_POINT   = 1'b0;
  localparam logic       ACT_VERTEX  = 1'b1;
  localparam logic [2:0] LAST_VERTEX = 3'd7;
  localparam logic [2:0] PT_QUERY    = 3'd4;

  typedef struct packed {
    logic                       action;
    logic [2:0]                 vertex_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } in_t;

  typedef struct packed {
    logic                        found;
    logic [2:0]                  tet_index;
    logic                        orientation_error;
    logic signed [WEIGHT_W-1:0]  weight_0;
    logic signed [WEIGHT_W-1:0]  weight_1;
    logic signed [WEIGHT_W-1:0]  weight_2;
    logic signed [WEIGHT_W-1:0]  weight_3;
    logic signed [WEIGHT_W-1:0]  weight_4;
    logic signed [WEIGHT_W-1:0]  weight_5;
    logic signed [WEIGHT_W-1:0]  weight_6;
    logic signed [WEIGHT_W-1:0]  weight_7;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       rd_en;
    logic [2:0] rd_node;
    logic       rd_is_query;
    logic       cap_en;
    logic [1:0] cap_slot;
    logic       diff_en;
    logic       mul_en;
    logic       acc_en;
    logic [3:0] step;
    logic       det_save;
    logic [2:0] det_sel;
    logic       tet_eval;
    logic [2:0] tet_idx;
    logic       div_init;
    logic [1:0] div_sel;
    logic       div_step;
    logic       div_wb;
    logic [2:0] div_node;
  } cmd_t;

  // Local node of corner j of tetrahedron k
  function automatic logic [2:0] tet_node(input logic [2:0] k, input logic [1:0] j);
    logic [2:0] n;
    case ({k, j})
      5'b000_00: n = 3'd0;
      5'b000_01: n = 3'd2;
      5'b000_10: n = 3'd3;
      5'b000_11: n = 3'd7;
      5'b001_00: n = 3'd0;
      5'b001_01: n = 3'd1;
      5'b001_10: n = 3'd2;
      5'b001_11: n = 3'd5;
      5'b010_00: n = 3'd4;
      5'b010_01: n = 3'd7;
      5'b010_10: n = 3'd5;
      5'b010_11: n = 3'd0;
      5'b011_00: n = 3'd5;
      5'b011_01: n = 3'd7;
      5'b011_10: n = 3'd6;
      5'b011_11: n = 3'd2;
      5'b100_00: n = 3'd5;
      5'b100_01: n = 3'd7;
      5'b100_10: n = 3'd2;
      5'b100_11: n = 3'd0;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // Row p of determinant di: a tetra corner (0..3) or the query point
  function automatic logic [2:0] det_point(input logic [2:0] di, input logic [1:0] p);
    logic [2:0] c;
    case (di)
      3'd0:    c = {1'b0, p};
      3'd1: begin
        case (p)
          2'd0:    c = 3'd1;
          2'd1:    c = 3'd3;
          2'd2:    c = 3'd2;
          default: c = PT_QUERY;
        endcase
      end
      3'd2: begin
        case (p)
          2'd0:    c = 3'd2;
          2'd1:    c = 3'd3;
          2'd2:    c = 3'd0;
          default: c = PT_QUERY;
        endcase
      end
      3'd3: begin
        case (p)
          2'd0:    c = 3'd0;
          2'd1:    c = 3'd3;
          2'd2:    c = 3'd1;
          default: c = PT_QUERY;
        endcase
      end
      default: begin
        case (p)
          2'd0:    c = 3'd0;
          2'd1:    c = 3'd1;
          2'd2:    c = 3'd2;
          default: c = PT_QUERY;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/phtl_ctrl.sv
// ---------------------------------------------------------------------------
// phtl_ctrl: sequencer of the point-in-brick locator
// Walks tetrahedra, determinant rows, multiply steps and divisions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phtl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          action,
  input  wire logic [2:0]    vertex_index,
  input  wire logic          hit,
  output phtl_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DIFF, S_MUL, S_SAVE, S_EVAL, S_DINIT, S_DRUN, S_DWB, S_DONE
  } state_t;

  state_t     state;
  logic [2:0] k;
  logic [2:0] di;
  logic [2:0] fc;
  logic [3:0] step;
  logic       phase;
  logic [1:0] j;
  logic [4:0] dcnt;
  logic       accept;
  logic       trigger;
  logic [2:0] code;

  assign accept  = start && (state == S_IDLE);
  assign trigger = (action == phtl_pkg::ACT_VERTEX) && (vertex_index == phtl_pkg::LAST_VERTEX);
  assign busy    = (state != S_IDLE);
  assign done    = (state == S_DONE);
  assign code    = phtl_pkg::det_point(di, fc[1:0]);

  // Decode commands for the datapath
  always_comb begin
    cmd             = '0;
    cmd.load        = accept;
    cmd.clear       = accept && trigger;
    cmd.rd_node     = phtl_pkg::tet_node(k, code[1:0]);
    cmd.rd_is_query = (code == phtl_pkg::PT_QUERY);
    cmd.cap_slot    = 2'(fc - 3'd1);
    cmd.step        = step;
    cmd.det_sel     = di;
    cmd.tet_idx     = k;
    cmd.div_sel     = j;
    cmd.div_node    = phtl_pkg::tet_node(k, j);
    case (state)
      S_FETCH: begin
        cmd.rd_en  = (fc != 3'd4);
        cmd.cap_en = (fc != 3'd0);
      end
      S_DIFF:  cmd.diff_en  = 1'b1;
      S_MUL: begin
        cmd.mul_en = !phase;
        cmd.acc_en = phase;
      end
      S_SAVE:  cmd.det_save = 1'b1;
      S_EVAL:  cmd.tet_eval = 1'b1;
      S_DINIT: cmd.div_init = 1'b1;
      S_DRUN:  cmd.div_step = 1'b1;
      S_DWB:   cmd.div_wb   = 1'b1;
      default: ;
    endcase
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      di    <= '0;
      fc    <= '0;
      step  <= '0;
      phase <= 1'b0;
      j     <= '0;
      dcnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && trigger) begin
            state <= S_FETCH;
            k     <= '0;
            di    <= '0;
            fc    <= '0;
          end
        end
        S_FETCH: begin
          if (fc == 3'd4) begin
            state <= S_DIFF;
            fc    <= '0;
          end else begin
            fc <= fc + 3'd1;
          end
        end
        S_DIFF: begin
          state <= S_MUL;
          step  <= '0;
          phase <= 1'b0;
        end
        S_MUL: begin
          phase <= !phase;
          if (phase) begin
            if (step == 4'd11) state <= S_SAVE;
            else step <= step + 4'd1;
          end
        end
        S_SAVE: begin
          if (di == 3'd4) begin
            state <= S_EVAL;
          end else begin
            di    <= di + 3'd1;
            state <= S_FETCH;
          end
        end
        S_EVAL: begin
          if (hit) begin
            state <= S_DINIT;
            j     <= '0;
          end else if (k == 3'd4) begin
            state <= S_DONE;
          end else begin
            k     <= k + 3'd1;
            di    <= '0;
            state <= S_FETCH;
          end
        end
        S_DINIT: begin
          state <= S_DRUN;
          dcnt  <= '0;
        end
        S_DRUN: begin
          if (dcnt == 5'(phtl_pkg::QUOT_BITS - 1)) state <= S_DWB;
          else dcnt <= dcnt + 5'd1;
        end
        S_DWB: begin
          if (j == 2'd3) begin
            state <= S_DONE;
          end else begin
            j     <= j + 2'd1;
            state <= S_DINIT;
          end
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/phtl_datapath.sv
// ---------------------------------------------------------------------------
// phtl_datapath: storage and arithmetic of the point-in-brick locator
// Vertex memory, shared 35x35 multiplier, accumulator, restoring divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phtl_datapath #(
  parameter int WEIGHT_FRAC_BITS = phtl_pkg::WEIGHT_FRAC_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire phtl_pkg::cmd_t               cmd,
  input  wire phtl_pkg::in_t                item,
  input  wire logic                         cfg_we,
  input  wire logic [phtl_pkg::TOL_W-1:0]   cfg_data,
  output logic                              hit,
  output phtl_pkg::out_t                    result
);

  localparam int CW    = phtl_pkg::COORD_W;
  localparam int DW    = phtl_pkg::DIFF_W;
  localparam int MW    = phtl_pkg::MOP_W;
  localparam int PW    = phtl_pkg::PROD_W;
  localparam int NW    = phtl_pkg::MINOR_W;
  localparam int LW    = phtl_pkg::MLO_W;
  localparam int TW    = phtl_pkg::DET_W;
  localparam int QB    = phtl_pkg::QUOT_BITS;
  localparam int DIV_W = TW + QB + 1;

  logic [3*CW-1:0]         vmem [phtl_pkg::NODE_COUNT];
  logic [3*CW-1:0]         rd_data;
  logic                    rd_is_query;
  logic signed [CW-1:0]    qp [3];
  logic [phtl_pkg::TOL_W-1:0] tol;
  logic signed [CW-1:0]    pt [4][3];
  logic signed [DW-1:0]    du [3];
  logic signed [DW-1:0]    dv [3];
  logic signed [DW-1:0]    dw [3];
  logic signed [PW-1:0]    prod;
  logic signed [NW-1:0]    minor;
  logic signed [TW-1:0]    acc;
  logic signed [TW-1:0]    dets [phtl_pkg::DET_COUNT];
  logic                    found;
  logic                    oerr;
  logic [2:0]              tet;
  logic [DIV_W-1:0]        rem_r;
  logic [DIV_W-1:0]        den_r;
  logic [QB-1:0]           quo;
  logic                    neg;
  logic                    sat;
  logic signed [phtl_pkg::WEIGHT_W-1:0] weights [phtl_pkg::NODE_COUNT];

  logic [1:0]              mk;
  logic [1:0]              msub;
  logic [1:0]              j1;
  logic [1:0]              j2;
  logic signed [MW-1:0]    op_a;
  logic signed [MW-1:0]    op_b;
  logic signed [TW-1:0]    term;
  logic signed [TW-1:0]    tol_ext;
  logic signed [TW-1:0]    s_sel;
  logic [TW-1:0]           mag_s;
  logic [TW-1:0]           mag_v;
  logic [QB:0]             quo_ext;
  logic signed [phtl_pkg::WEIGHT_W-1:0] wres;

  function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] a);
    return DW'(a);
  endfunction

  function automatic logic signed [DW-1:0] pick3(input logic signed [DW-1:0] a0,
                                                 input logic signed [DW-1:0] a1,
                                                 input logic signed [DW-1:0] a2,
                                                 input logic [1:0] sel);
    logic signed [DW-1:0] r;
    case (sel)
      2'd1:    r = a1;
      2'd2:    r = a2;
      default: r = a0;
    endcase
    return r;
  endfunction

  // Hold vertices and the read port of the vertex memory
  always_ff @(posedge clk) begin
    if (cmd.load && (item.action == phtl_pkg::ACT_VERTEX)) begin
      vmem[item.vertex_index] <= {item.coord_x, item.coord_y, item.coord_z};
    end
    if (cmd.rd_en) begin
      rd_data     <= vmem[cmd.rd_node];
      rd_is_query <= cmd.rd_is_query;
    end
  end

  // Hold the query point and the tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      qp[0] <= '0;
      qp[1] <= '0;
      qp[2] <= '0;
      tol   <= phtl_pkg::TOL_RESET;
    end else begin
      if (cmd.load && (item.action == phtl_pkg::ACT_POINT)) begin
        qp[0] <= item.coord_x;
        qp[1] <= item.coord_y;
        qp[2] <= item.coord_z;
      end
      if (cfg_we) tol <= cfg_data;
    end
  end

  // Capture determinant rows and form edge vectors
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      pt[cmd.cap_slot][0] <= rd_is_query ? qp[0] : rd_data[3*CW-1:2*CW];
      pt[cmd.cap_slot][1] <= rd_is_query ? qp[1] : rd_data[2*CW-1:CW];
      pt[cmd.cap_slot][2] <= rd_is_query ? qp[2] : rd_data[CW-1:0];
    end
    if (cmd.diff_en) begin
      for (int i = 0; i < 3; i++) begin
        du[i] <= sx(pt[1][i]) - sx(pt[0][i]);
        dv[i] <= sx(pt[2][i]) - sx(pt[0][i]);
        dw[i] <= sx(pt[3][i]) - sx(pt[0][i]);
      end
    end
  end

  // Select multiplier operands for the cofactor expansion
  always_comb begin
    mk   = cmd.step[3:2];
    msub = cmd.step[1:0];
    j1   = (mk == 2'd0) ? 2'd1 : 2'd0;
    j2   = (mk == 2'd2) ? 2'd1 : 2'd2;
    case (msub)
      2'd0: begin
        op_a = MW'(pick3(dv[0], dv[1], dv[2], j1));
        op_b = MW'(pick3(dw[0], dw[1], dw[2], j2));
      end
      2'd1: begin
        op_a = MW'(pick3(dw[0], dw[1], dw[2], j1));
        op_b = MW'(pick3(dv[0], dv[1], dv[2], j2));
      end
      2'd2: begin
        op_a = MW'(pick3(du[0], du[1], du[2], mk));
        op_b = $signed({1'b0, minor[LW-1:0]});
      end
      default: begin
        op_a = MW'(pick3(du[0], du[1], du[2], mk));
        op_b = MW'($signed(minor[NW-1:LW]));
      end
    endcase
    term = (msub == 2'd3) ? (TW'(prod) <<< LW) : TW'(prod);
  end

  // Multiply, then fold the product into the minor or the determinant
  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= op_a * op_b;
    if (cmd.diff_en) acc <= '0;
    if (cmd.acc_en) begin
      case (msub)
        2'd0:    minor <= $signed(prod[NW-1:0]);
        2'd1:    minor <= minor - $signed(prod[NW-1:0]);
        default: acc   <= (mk == 2'd1) ? acc - term : acc + term;
      endcase
    end
    if (cmd.det_save) dets[cmd.det_sel] <= acc;
  end

  // Test the sub-volumes against the tolerance
  always_comb begin
    tol_ext = $signed({{(TW - phtl_pkg::TOL_W){1'b0}}, tol});
    hit     = (dets[0] != '0);
    for (int i = 1; i < phtl_pkg::DET_COUNT; i++) begin
      if ((dets[i] + tol_ext) <= $signed(TW'(0))) hit = 1'b0;
    end
  end

  // Divider operands and the saturated weight
  always_comb begin
    s_sel   = dets[3'(cmd.div_sel) + 3'd1];
    mag_s   = s_sel[TW-1] ? TW'(-s_sel) : s_sel;
    mag_v   = dets[0][TW-1] ? TW'(-dets[0]) : dets[0];
    quo_ext = {1'b0, quo};
    if (sat) wres = neg ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
    else     wres = neg ? $signed(-quo_ext) : $signed(quo_ext);
  end

  // Run the restoring division and keep flags and weights
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= DIV_W'(mag_s) << WEIGHT_FRAC_BITS;
      den_r <= DIV_W'(mag_v) << (QB - 1);
      sat   <= (DIV_W'(mag_s) << WEIGHT_FRAC_BITS) >= (DIV_W'(mag_v) << QB);
      neg   <= s_sel[TW-1] ^ dets[0][TW-1];
      quo   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= den_r) begin
        rem_r <= rem_r - den_r;
        quo   <= {quo[QB-2:0], 1'b1};
      end else begin
        quo   <= {quo[QB-2:0], 1'b0};
      end
      den_r <= den_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      oerr  <= 1'b0;
      tet   <= '0;
    end else if (cmd.clear) begin
      found <= 1'b0;
      oerr  <= 1'b0;
      tet   <= '0;
    end else if (cmd.tet_eval) begin
      if (dets[0][TW-1]) oerr <= 1'b1;
      if (hit) begin
        found <= 1'b1;
        tet   <= cmd.tet_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int i = 0; i < phtl_pkg::NODE_COUNT; i++) weights[i] <= '0;
    end else if (cmd.div_wb) begin
      weights[cmd.div_node] <= wres;
    end
  end

  assign result.found             = found;
  assign result.tet_index         = tet;
  assign result.orientation_error = oerr;
  assign result.weight_0          = weights[0];
  assign result.weight_1          = weights[1];
  assign result.weight_2          = weights[2];
  assign result.weight_3          = weights[3];
  assign result.weight_4          = weights[4];
  assign result.weight_5          = weights[5];
  assign result.weight_6          = weights[6];
  assign result.weight_7          = weights[7];

endmodule

`default_nettype wire

>>> rtl/core/point_in_hex_tet_locator_unit.sv
// ---------------------------------------------------------------------------
// point_in_hex_tet_locator_unit: locate a point in a brick split in 5 tetras
//
//   channel   handshake               payload
//   item      start / busy            phtl_pkg::in_t (point or one vertex)
//   result    done (one-cycle strobe) phtl_pkg::out_t (flags, eight weights)
//   config    cfg_valid / cfg_ready   cfg_data (inside tolerance)
//
// A point load or a vertex 0..6 load leaves busy low.
// A vertex 7 load runs five determinants per tetrahedron examined, each
// set by the shared multiplier, and one test, then four divisions of the
// one-bit-per-cycle divider for the winner, then the one-cycle result
// strobe. Reset is synchronous; the result cannot be stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_in_hex_tet_locator_unit #(
  parameter int WEIGHT_FRAC_BITS = phtl_pkg::WEIGHT_FRAC_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire phtl_pkg::in_t               item,
  output logic                             done,
  output phtl_pkg::out_t                   result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [phtl_pkg::TOL_W-1:0]  cfg_data
);

  phtl_pkg::cmd_t cmd;
  logic           hit;

  assign cfg_ready = 1'b1;

  phtl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (item.action),
    .vertex_index (item.vertex_index),
    .hit          (hit),
    .cmd          (cmd),
    .busy         (busy),
    .done         (done)
  );

  phtl_datapath #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .hit      (hit),
    .result   (result)
  );

  // A strobe only ends a search
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a search");

  // A last-vertex transaction starts a search
  a_trigger: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.action == phtl_pkg::ACT_VERTEX) &&
     (item.vertex_index == phtl_pkg::LAST_VERTEX)) |=> busy)
    else $error("last vertex did not start a search");

  // One result per search
  a_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result repeated");

  // Not found reports index zero
  a_notfound: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.tet_index == 3'd0))
    else $error("index set without a hit");

endmodule

`default_nettype wire
